// File: hw/rtl/mono_framebuffer_rect_fill_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle fill framebuffer
// Shared shorthands for concurrent checks on clk_i, gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_RECT_FILL_DEFINES_SVH
`define MONO_FRAMEBUFFER_RECT_FILL_DEFINES_SVH

// Check that an expression holds at every edge out of reset
`define MFRF_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("framebuffer check failed");

// Check that a condition implies another in the same cycle
`define MFRF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framebuffer check failed");

// Check that a condition implies another in the next cycle
`define MFRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framebuffer check failed");

`endif

// File: hw/rtl/mfrf_pkg.sv
// ----------------------------------------------------------------------------
// mfrf_pkg
// Geometry constants, command types and address helper for the framebuffer.
// ----------------------------------------------------------------------------
package mfrf_pkg;

  // Display geometry
  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int ROWS    = PAGES * 8;
  localparam int DEPTH   = COLUMNS * PAGES;

  // Field widths of the ports
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int RPAGE_W = 3;
  localparam int BYTE_W  = 8;

  // Internal index widths
  localparam int CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int PIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = $clog2(DEPTH);

  // Command queue between front and back
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    K_DRAW     = 2'd0,
    K_SKIP     = 2'd1,
    K_READ     = 2'd2,
    K_READ_OFF = 2'd3
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_DRAW  = 3'd2,
    ST_DRAIN = 3'd3,
    ST_RDATA = 3'd4
  } back_state_e;

  // Classified command word
  typedef struct packed {
    cmd_kind_e          kind;
    logic [CIDX_W-1:0]  col0;
    logic [CIDX_W-1:0]  col1;
    logic [PIDX_W-1:0]  pg_lo;
    logic [PIDX_W-1:0]  pg_hi;
    logic [BYTE_W-1:0]  mask_hi;
    logic [BYTE_W-1:0]  mask_lo;
    logic               light;
    logic [ADDR_W-1:0]  raddr;
  } cmd_t;

  // Store address of one page byte: column * PAGES + page
  function automatic logic [ADDR_W-1:0] calc_addr(logic [CIDX_W-1:0] col,
                                                   logic [PIDX_W-1:0] pg);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(col) * ADDR_W'(PAGES);
    return base + ADDR_W'(pg);
  endfunction

endpackage

// File: hw/rtl/mfrf_ram.sv
// ----------------------------------------------------------------------------
// mfrf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mfrf_front.sv
// ----------------------------------------------------------------------------
// mfrf_front
// Classifies an incoming word: clamps the rectangle, maps rows to pages
// and edge masks, or forms the read address.
// ----------------------------------------------------------------------------
module mfrf_front
  import mfrf_pkg::*;
(
  input  logic               op_i,
  input  logic [COL_W-1:0]   col_first_i,
  input  logic [ROW_W-1:0]   row_first_i,
  input  logic [COL_W-1:0]   col_last_i,
  input  logic [ROW_W-1:0]   row_last_i,
  input  logic               light_i,
  input  logic [COL_W-1:0]   read_col_i,
  input  logic [RPAGE_W-1:0] read_page_i,
  output cmd_t               cmd_o
);

  logic               rect_empty;
  logic               read_off;
  logic [ROW_W-1:0]   row_last_c;
  logic [ROW_W-4:0]   blk_first;
  logic [ROW_W-4:0]   blk_last;

  // Drop reversed corners and rectangles wholly off the store
  assign rect_empty = (col_first_i > col_last_i) || (row_first_i > row_last_i) ||
                      (int'(col_first_i) >= COLUMNS) || (int'(row_first_i) >= ROWS);

  // Clamp the far row to the store
  assign row_last_c = (int'(row_last_i) > ROWS - 1) ? ROW_W'(ROWS - 1) : row_last_i;

  assign blk_first = row_first_i[ROW_W-1:3];
  assign blk_last  = row_last_c[ROW_W-1:3];

  assign read_off = (int'(read_col_i) >= COLUMNS) || (int'(read_page_i) >= PAGES);

  // Build the command word
  always_comb begin
    cmd_o         = '0;
    cmd_o.col0    = CIDX_W'(col_first_i);
    cmd_o.col1    = (int'(col_last_i) > COLUMNS - 1) ? CIDX_W'(COLUMNS - 1)
                                                     : CIDX_W'(col_last_i);
    cmd_o.pg_hi   = PIDX_W'(PAGES - 1) - PIDX_W'(blk_first);
    cmd_o.pg_lo   = PIDX_W'(PAGES - 1) - PIDX_W'(blk_last);
    cmd_o.mask_hi = 8'hFF >> row_first_i[2:0];
    cmd_o.mask_lo = 8'hFF << (3'd7 - row_last_c[2:0]);
    cmd_o.light   = light_i;
    cmd_o.raddr   = calc_addr(CIDX_W'(read_col_i), PIDX_W'(read_page_i));
    if (op_i == OP_READ) begin
      cmd_o.kind = read_off ? K_READ_OFF : K_READ;
    end else begin
      cmd_o.kind = rect_empty ? K_SKIP : K_DRAW;
    end
  end

endmodule

// File: hw/rtl/mfrf_fifo.sv
// ----------------------------------------------------------------------------
// mfrf_fifo
// Short command queue that decouples the classifier from the store engine.
// ----------------------------------------------------------------------------
module mfrf_fifo
  import mfrf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t                entry_q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FQ_PTR_W:0]   cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == (FQ_PTR_W + 1)'(FQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_q + FQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_q + FQ_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (FQ_PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (FQ_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/mfrf_back.sv
// ----------------------------------------------------------------------------
// mfrf_back
// Store engine: clears the store after reset, walks rectangles with a
// pipelined read-modify-write, serves reads and holds the result word.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_rect_fill_defines.svh"

module mfrf_back
  import mfrf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              clearing_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [BYTE_W-1:0] page_byte_o,
  output logic              was_read_o
);

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [CIDX_W-1:0] col_q, col_d;
  logic [PIDX_W-1:0] pg_q, pg_d;
  cmd_t              cmd_q, cmd_d;
  logic              wr_pend_q, wr_pend_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [BYTE_W-1:0] wr_mask_q, wr_mask_d;
  logic              res_valid_q, res_valid_d;
  logic [BYTE_W-1:0] res_byte_q, res_byte_d;
  logic              res_read_q, res_read_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] cur_mask;
  logic [BYTE_W-1:0] merged;
  logic [ADDR_W-1:0] cur_addr;

  mfrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Mask of rows touched in the current page byte
  always_comb begin
    cur_mask = 8'hFF;
    if (pg_q == cmd_q.pg_hi) begin
      cur_mask = cur_mask & cmd_q.mask_hi;
    end
    if (pg_q == cmd_q.pg_lo) begin
      cur_mask = cur_mask & cmd_q.mask_lo;
    end
  end

  assign cur_addr = calc_addr(col_q, pg_q);
  assign merged   = cmd_q.light ? (ram_rdata | wr_mask_q) : (ram_rdata & ~wr_mask_q);

  // Next state, store access and result
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    col_d       = col_q;
    pg_d        = pg_q;
    cmd_d       = cmd_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    wr_mask_d   = wr_mask_q;
    res_valid_d = res_valid_q && !pop_i;
    res_byte_d  = res_byte_q;
    res_read_d  = res_read_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_addr_q;
    ram_wdata   = merged;
    ram_re      = 1'b0;
    ram_raddr   = cur_addr;
    cmd_pop_o   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && !res_valid_q) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            K_DRAW: begin
              cmd_d   = cmd_i;
              col_d   = cmd_i.col0;
              pg_d    = cmd_i.pg_lo;
              state_d = ST_DRAW;
            end
            K_SKIP: begin
              res_valid_d = 1'b1;
              res_byte_d  = '0;
              res_read_d  = 1'b0;
            end
            K_READ: begin
              ram_re    = 1'b1;
              ram_raddr = cmd_i.raddr;
              state_d   = ST_RDATA;
            end
            K_READ_OFF: begin
              res_valid_d = 1'b1;
              res_byte_d  = '0;
              res_read_d  = 1'b1;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DRAW: begin
        // Write back the byte read last cycle, read the next one
        ram_we    = wr_pend_q;
        ram_re    = 1'b1;
        wr_pend_d = 1'b1;
        wr_addr_d = cur_addr;
        wr_mask_d = cur_mask;
        if (pg_q == cmd_q.pg_hi) begin
          if (col_q == cmd_q.col1) begin
            state_d = ST_DRAIN;
          end else begin
            col_d = col_q + CIDX_W'(1);
            pg_d  = cmd_q.pg_lo;
          end
        end else begin
          pg_d = pg_q + PIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        ram_we      = 1'b1;
        wr_pend_d   = 1'b0;
        res_valid_d = 1'b1;
        res_byte_d  = '0;
        res_read_d  = 1'b0;
        state_d     = ST_IDLE;
      end
      ST_RDATA: begin
        res_valid_d = 1'b1;
        res_byte_d  = ram_rdata;
        res_read_d  = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      wr_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      wr_pend_q   <= wr_pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    pg_q       <= pg_d;
    cmd_q      <= cmd_d;
    wr_addr_q  <= wr_addr_d;
    wr_mask_q  <= wr_mask_d;
    res_byte_q <= res_byte_d;
    res_read_q <= res_read_d;
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign empty_o     = !res_valid_q;
  assign page_byte_o = res_byte_q;
  assign was_read_o  = res_read_q;

  // Never read and write one byte in the same cycle
  `MFRF_ASSERT_IMPL(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
  // The result slot stays free while a rectangle is being drawn
  `MFRF_ASSERT_IMPL(a_slot_free, state_q == ST_DRAW || state_q == ST_DRAIN, !res_valid_q)
  // The final write-back always has a byte in flight
  `MFRF_ASSERT_IMPL(a_drain_pend, state_q == ST_DRAIN, wr_pend_q)
  // No command is taken during the clearing pass
  `MFRF_ASSERT_IMPL(a_no_pop_clear, state_q == ST_CLEAR, !cmd_pop_o)
  // A finished read shows up as a read result
  `MFRF_ASSERT_NEXT(a_read_result, state_q == ST_RDATA, res_valid_q && res_read_q)

endmodule

// File: hw/rtl/mono_framebuffer_rect_fill.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_rect_fill
// 128x64 one-bit page framebuffer with rectangle fill and byte read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the word fields and raise push; a word is
//   taken on a clock edge with push high and full low. op_i = 0 sets or
//   clears an inclusive rectangle, op_i = 1 reads one page byte.
//   Result side is a queue: while empty is low, page_byte_o and was_read_o
//   carry the oldest result; pop takes it. Every word yields one result.
//   A classifier feeds a two-entry command queue, so words keep arriving
//   while the engine is busy or a result waits to be popped.
//   Draw: a draw spanning C columns and P page bytes per column does one
//   read-modify-write per page byte through the single-port-pair store RAM
//   and then writes back its last byte; a read fetches one byte from the RAM.
//   A skipped draw or off-store read posts a result with no store access.
//   Reset: the store is cleared by a sweep of all 1024 bytes, one byte per
//   cycle; full stays high during the sweep.
//   Stall: with a result unpopped the engine waits before its next command,
//   and once the command queue fills, full rises.
// ----------------------------------------------------------------------------
module mono_framebuffer_rect_fill
  import mfrf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               op_i,
  input  logic [COL_W-1:0]   col_first_i,
  input  logic [ROW_W-1:0]   row_first_i,
  input  logic [COL_W-1:0]   col_last_i,
  input  logic [ROW_W-1:0]   row_last_i,
  input  logic               light_i,
  input  logic [COL_W-1:0]   read_col_i,
  input  logic [RPAGE_W-1:0] read_page_i,
  output logic               empty,
  input  logic               pop,
  output logic [BYTE_W-1:0]  page_byte_o,
  output logic               was_read_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_full;
  logic queue_valid;
  logic queue_pop;
  logic clearing;

  // Classify incoming words
  mfrf_front u_front (
    .op_i        (op_i),
    .col_first_i (col_first_i),
    .row_first_i (row_first_i),
    .col_last_i  (col_last_i),
    .row_last_i  (row_last_i),
    .light_i     (light_i),
    .read_col_i  (read_col_i),
    .read_page_i (read_page_i),
    .cmd_o       (front_cmd)
  );

  // Hold commands between classifier and engine
  mfrf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .data_o  (queue_cmd)
  );

  // Carry out commands on the store
  mfrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .clearing_o  (clearing),
    .pop_i       (pop),
    .empty_o     (empty),
    .page_byte_o (page_byte_o),
    .was_read_o  (was_read_o)
  );

  assign full = queue_full || clearing;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the page framebuffer with rectangle fill and byte read-back.
// Words are queued up front: a directed opening (corners of the screen, full
// and single-pixel fills, crossed corners, page-straddling rectangles, ignored
// fields), then random draws and reads. About half the random reads hit
// the last well-formed rectangle. A shadow store predicts each result word.
// Each popped word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import mfrf_pkg::*;

  typedef struct packed {
    op_e                op;
    logic [COL_W-1:0]   col_first;
    logic [ROW_W-1:0]   row_first;
    logic [COL_W-1:0]   col_last;
    logic [ROW_W-1:0]   row_last;
    logic               light;
    logic [COL_W-1:0]   read_col;
    logic [RPAGE_W-1:0] read_page;
  } fb_word_t;

  typedef struct packed {
    fb_word_t word;
    logic     drain_first;
  } fb_stim_t;

  typedef struct packed {
    logic [BYTE_W-1:0] page_byte;
    logic              was_read;
  } fb_result_t;

  localparam int STALL_LIMIT = 8000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_WORDS = 562;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               op_i = 1'b0;
  logic [COL_W-1:0]   col_first_i = '0;
  logic [ROW_W-1:0]   row_first_i = '0;
  logic [COL_W-1:0]   col_last_i = '0;
  logic [ROW_W-1:0]   row_last_i = '0;
  logic               light_i = 1'b0;
  logic [COL_W-1:0]   read_col_i = '0;
  logic [RPAGE_W-1:0] read_page_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [BYTE_W-1:0]  page_byte_o;
  logic               was_read_o;

  // Shadow of the display store, cleared like the block after reset
  logic [BYTE_W-1:0] shadow_store [DEPTH];

  fb_stim_t   pending_words [$];
  fb_result_t owed_results [$];
  fb_word_t   word_on_bus;
  fb_stim_t   next_stim;
  fb_result_t oldest_owed;

  int n_planned = 0;
  int n_in = 0;
  int n_out = 0;
  int n_errors = 0;
  int n_draws = 0;
  int n_crossed = 0;
  int n_reads = 0;
  int n_lit_reads = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_cycles = 0;

  // Last well-formed rectangle, used to aim reads at drawn pixels
  int lr_c0 = 0, lr_r0 = 0, lr_c1 = 127, lr_r1 = 63;

  mono_framebuffer_rect_fill i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .col_first_i (col_first_i),
    .row_first_i (row_first_i),
    .col_last_i  (col_last_i),
    .row_last_i  (row_last_i),
    .light_i     (light_i),
    .read_col_i  (read_col_i),
    .read_page_i (read_page_i),
    .empty       (empty),
    .pop         (pop),
    .page_byte_o (page_byte_o),
    .was_read_o  (was_read_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one word to the shadow store and return the result it yields
  function automatic fb_result_t fb_apply_word(fb_word_t w);
    fb_result_t res;
    int pg;
    res = '0;
    if (w.op == OP_READ) begin
      res.was_read = 1'b1;
      if (int'(w.read_col) < COLUMNS && int'(w.read_page) < PAGES)
        res.page_byte = shadow_store[int'(w.read_col) * PAGES + int'(w.read_page)];
    end else if (w.col_first <= w.col_last && w.row_first <= w.row_last) begin
      for (int c = int'(w.col_first); c <= int'(w.col_last); c++) begin
        for (int r = int'(w.row_first); r <= int'(w.row_last); r++) begin
          if (c < COLUMNS && r < ROWS) begin
            pg = PAGES - 1 - r / 8;
            shadow_store[c * PAGES + pg][7 - r % 8] = w.light;
          end
        end
      end
    end
    return res;
  endfunction

  // Queue a draw word; the read fields carry noise
  function automatic void add_draw(int c0, int r0, int c1, int r1, logic lit,
                                   logic drain);
    fb_stim_t s;
    s.word.op        = OP_DRAW;
    s.word.col_first = COL_W'(c0);
    s.word.row_first = ROW_W'(r0);
    s.word.col_last  = COL_W'(c1);
    s.word.row_last  = ROW_W'(r1);
    s.word.light     = lit;
    s.word.read_col  = COL_W'($urandom);
    s.word.read_page = RPAGE_W'($urandom);
    s.drain_first    = drain;
    pending_words.push_back(s);
    n_draws++;
    if (c0 > c1 || r0 > r1)
      n_crossed++;
  endfunction

  // Queue a read word; the rectangle fields carry noise
  function automatic void add_read(int col, int page, logic drain);
    fb_stim_t s;
    s.word.op        = OP_READ;
    s.word.col_first = COL_W'($urandom);
    s.word.row_first = ROW_W'($urandom);
    s.word.col_last  = COL_W'($urandom);
    s.word.row_last  = ROW_W'($urandom);
    s.word.light     = 1'($urandom);
    s.word.read_col  = COL_W'(col);
    s.word.read_page = RPAGE_W'(page);
    s.drain_first    = drain;
    pending_words.push_back(s);
    n_reads++;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", n_out, what, got, want);
    n_errors++;
  endtask

  // Driver: offer the next pending word, hold it until the block takes it
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        owed_results.push_back(fb_apply_word(word_on_bus));
        n_in++;
      end
      if (!push || !full) begin
        if (pending_words.size() != 0
            && (!pending_words[0].drain_first || owed_results.size() == 0)
            && ((n_in >= 250 && n_in < 350) || $urandom_range(99) >= 12)) begin
          next_stim   = pending_words.pop_front();
          word_on_bus = next_stim.word;
          op_i        <= next_stim.word.op;
          col_first_i <= next_stim.word.col_first;
          row_first_i <= next_stim.word.row_first;
          col_last_i  <= next_stim.word.col_last;
          row_last_i  <= next_stim.word.row_last;
          light_i     <= next_stim.word.light;
          read_col_i  <= next_stim.word.read_col;
          read_page_i <= next_stim.word.read_page;
          push        <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped word, then decide whether to pop next cycle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_out++;
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected word, page_byte", 32'(page_byte_o), '0);
        end else begin
          oldest_owed = owed_results.pop_front();
          if (page_byte_o !== oldest_owed.page_byte)
            report_mismatch("page_byte", 32'(page_byte_o), 32'(oldest_owed.page_byte));
          if (was_read_o !== oldest_owed.was_read)
            report_mismatch("was_read", 32'(was_read_o), 32'(oldest_owed.was_read));
          if (oldest_owed.was_read && oldest_owed.page_byte != '0)
            n_lit_reads++;
        end
      end
      // Hold off once for a long stretch so the block backs up to full
      if (!hold_done && n_in >= 120) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (n_out >= 250 && n_out < 350) || $urandom_range(99) >= 12;
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int pick, c0, c1, r0, r1, row;
    logic drain;

    foreach (shadow_store[i])
      shadow_store[i] = '0;

    // Directed opening: dark screen, full fill, single pixels, crossed corners
    add_read(0, 0, 1'b0);
    add_read(127, 7, 1'b0);
    add_draw(0, 0, 127, 63, 1'b1, 1'b0);
    add_read(0, 0, 1'b1);
    add_read(127, 7, 1'b0);
    add_read(64, 3, 1'b0);
    add_draw(0, 0, 0, 0, 1'b0, 1'b0);
    add_read(0, 7, 1'b0);
    add_draw(127, 63, 127, 63, 1'b0, 1'b0);
    add_read(127, 0, 1'b0);
    add_draw(10, 0, 5, 63, 1'b0, 1'b0);
    add_read(7, 3, 1'b0);
    add_draw(0, 40, 127, 20, 1'b0, 1'b0);
    add_read(50, 2, 1'b0);
    // Rows straddling the page 7 / page 6 boundary
    add_draw(20, 3, 21, 12, 1'b0, 1'b0);
    add_read(20, 7, 1'b0);
    add_read(21, 6, 1'b0);
    add_draw(0, 0, 127, 63, 1'b0, 1'b1);
    add_read(127, 7, 1'b0);
    add_read(0, 0, 1'b0);

    // Random part: mostly small rectangles, half the reads aimed at the last well-formed one
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick  = $urandom_range(99);
      drain = (i == 60 || i == 300 || i == 480);
      if (pick < 45) begin
        if ($urandom_range(1)) begin
          row = $urandom_range(lr_r1, lr_r0);
          add_read($urandom_range(lr_c1, lr_c0), PAGES - 1 - row / 8, drain);
        end else begin
          add_read($urandom_range(127), $urandom_range(7), drain);
        end
      end else if (pick < 49) begin
        c0 = $urandom_range(7);
        r0 = $urandom_range(7);
        c1 = $urandom_range(127, 120);
        r1 = $urandom_range(63, 56);
        add_draw(c0, r0, c1, r1, 1'($urandom), drain);
        lr_c0 = c0; lr_r0 = r0; lr_c1 = c1; lr_r1 = r1;
      end else if (pick < 56) begin
        c0 = $urandom_range(127, 1);
        c1 = $urandom_range(c0 - 1, 0);
        r0 = $urandom_range(63, 1);
        r1 = $urandom_range(r0 - 1, 0);
        if ($urandom_range(1))
          add_draw(c0, $urandom_range(63), c1, $urandom_range(63), 1'($urandom), drain);
        else
          add_draw($urandom_range(127), r0, $urandom_range(127), r1, 1'($urandom), drain);
      end else begin
        c0 = $urandom_range(127);
        r0 = $urandom_range(63);
        c1 = (c0 + $urandom_range(15) > 127) ? 127 : c0 + $urandom_range(15);
        r1 = (r0 + $urandom_range(23) > 63) ? 63 : r0 + $urandom_range(23);
        add_draw(c0, r0, c1, r1, 1'($urandom), drain);
        lr_c0 = c0; lr_r0 = r0; lr_c1 = c1; lr_r1 = r1;
      end
    end
    n_planned = pending_words.size();

    // Hold reset, then release it at a rising edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to go in and every result to come back
    while (n_in < n_planned) @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("stimulus: %0d words, %0d draws (%0d with crossed corners), %0d reads",
             n_in, n_draws, n_crossed, n_reads);
    $display("results checked: %0d, reads of lit bytes: %0d, mismatches: %0d",
             n_out, n_lit_reads, n_errors);
    if (n_errors == 0 && owed_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: mono_framebuffer_rect_fill.f
+incdir+hw/rtl
hw/rtl/mfrf_pkg.sv
hw/rtl/mfrf_ram.sv
hw/rtl/mfrf_front.sv
hw/rtl/mfrf_fifo.sv
hw/rtl/mfrf_back.sv
hw/rtl/mono_framebuffer_rect_fill.sv
bench/tb_top.sv
